// ===== rtl/sensor_temp_pressure_compensation_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the compensation core
// Clocked, reset-gated same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SENSOR_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define SENSOR_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication
`define STPC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error("check failed");

// next-cycle implication
`define STPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error("check failed");

`endif

// ===== rtl/stpc_pkg.sv =====
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared widths, register codes, constants and beat types of the core.
// ----------------------------------------------------------------------------
package stpc_pkg;

	localparam int RawW     = 20;
	localparam int CalW     = 48;
	localparam int OutW     = 32;
	localparam int CfgIdxW  = 8;
	localparam int DivW     = 64;
	localparam int DivCells = DivW;
	localparam int FrontStages = 12;
	localparam int BackStages  = 5;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_TEMP_CALIB    = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESS_CALIB_A = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_CALIB_B = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_PRESS_CALIB_C = 8'd3;

	// formula constants
	localparam logic signed [32:0] FineOffset = 33'sd128000;
	localparam logic [20:0]        PressFull  = 21'd1048576;
	localparam logic [63:0]        PressScale = 64'd3125;
	localparam logic [63:0]        CalOffset  = 64'h0000_8000_0000_0000;
	localparam logic [31:0]        TempRound  = 32'd128;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} calib_t;

	// values that ride along with the divider
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic        neg;
		logic        dzero;
	} side_t;

	typedef struct packed {
		logic [DivW-1:0] rem;
		logic [DivW-1:0] num;
		logic [DivW-1:0] quo;
		logic [DivW-1:0] den;
		side_t           side;
	} div_t;

endpackage

// ===== rtl/stpc_div_cell.sv =====
// ----------------------------------------------------------------------------
// stpc_div_cell
// One restoring division step: yields one quotient bit and hands on.
// ----------------------------------------------------------------------------
`include "sensor_temp_pressure_compensation_core_macros.svh"

module stpc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vin,
	input  stpc_pkg::div_t din,
	output logic           vout,
	output stpc_pkg::div_t dout
);

	logic [stpc_pkg::DivW:0] rem_sh;
	logic [stpc_pkg::DivW:0] diff;
	logic                    ge;
	stpc_pkg::div_t          nxt;

	// shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh = {din.rem, din.num[stpc_pkg::DivW-1]};
		diff   = rem_sh - {1'b0, din.den};
		ge     = ~diff[stpc_pkg::DivW];
		nxt       = din;
		nxt.rem   = ge ? diff[stpc_pkg::DivW-1:0] : rem_sh[stpc_pkg::DivW-1:0];
		nxt.num   = {din.num[stpc_pkg::DivW-2:0], 1'b0};
		nxt.quo   = {din.quo[stpc_pkg::DivW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

	`STPC_ASSERT_NOW(a_rem_below_den, clk, arst_n, vout && !dout.side.dzero, dout.rem < dout.den)

endmodule

// ===== rtl/stpc_front.sv =====
// ----------------------------------------------------------------------------
// stpc_front
// Temperature math and the pressure terms up to the divider operands.
// ----------------------------------------------------------------------------
module stpc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vin,
	input  logic [stpc_pkg::RawW-1:0]     raw_temperature,
	input  logic [stpc_pkg::RawW-1:0]     raw_pressure,
	input  stpc_pkg::calib_t              cal,
	output logic                          vout,
	output stpc_pkg::div_t                dout
);

	logic [stpc_pkg::FrontStages-1:0] vld_q;

	logic [31:0] a_s1, d_s1;
	logic [20:0] pt_s1, pt_s2, pt_s3, pt_s4, pt_s5, pt_s6, pt_s7, pt_s8, pt_s9;
	logic [31:0] x1m_s2, dd_s2;
	logic [31:0] x1_s3, x2m_s3;
	logic [31:0] fine_s4;
	stpc_pkg::side_t sd_s5, sd_s6, sd_s7, sd_s8, sd_s9, sd_s10, sd_s11;
	logic signed [32:0] v1_s5;
	logic [63:0] sq_s6, m5_s6, m2_s6;
	logic [63:0] a_s7, d_s7, m5_s7, m2_s7;
	logic [63:0] v2_s8, w_s8, v2_s9;
	logic [63:0] w2m_s9;
	logic [63:0] den_s10, num0_s10, den_s11, num_s11;

	logic [31:0] t2x, t3x, x1_c, dd_sh, x2_c, t5_c, temp_c;
	logic signed [32:0] v1_c;
	logic signed [65:0] sq_full;
	logic signed [48:0] m5_full, m2_full;
	logic signed [63:0] a_c, d_c;
	logic [63:0] p4x, dsh_c, v2_c, w_c, den_c, num0_c, an_c, ad_c;

	always_comb begin
		t2x     = {{16{cal.t2[15]}}, cal.t2};
		t3x     = {{16{cal.t3[15]}}, cal.t3};
		x1_c    = $signed(x1m_s2) >>> 11;
		dd_sh   = $signed(dd_s2) >>> 12;
		x2_c    = $signed(x2m_s3) >>> 14;
		t5_c    = fine_s4 + (fine_s4 << 2) + stpc_pkg::TempRound;
		temp_c  = $signed(t5_c) >>> 8;
		v1_c    = $signed({fine_s4[31], fine_s4}) - stpc_pkg::FineOffset;
		sq_full = v1_s5 * v1_s5;
		m5_full = v1_s5 * $signed(cal.p5);
		m2_full = v1_s5 * $signed(cal.p2);
		a_c     = $signed(sq_s6) * $signed(cal.p6);
		d_c     = $signed(sq_s6) * $signed(cal.p3);
		p4x     = {{48{cal.p4[15]}}, cal.p4};
		dsh_c   = $signed(d_s7) >>> 8;
		v2_c    = a_s7 + (m5_s7 << 17) + (p4x << 35);
		w_c     = dsh_c + (m2_s7 << 12);
		den_c   = $signed(w2m_s9) >>> 33;
		num0_c  = ({43'b0, pt_s9} << 31) - v2_s9;
		an_c    = num_s11[63] ? (64'd0 - num_s11) : num_s11;
		ad_c    = den_s11[63] ? (64'd0 - den_s11) : den_s11;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[stpc_pkg::FrontStages-2:0], vin};
		end
	end

	assign vout = vld_q[stpc_pkg::FrontStages-1];

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offsets from T1, pressure complement
			a_s1  <= {15'b0, raw_temperature[19:3]} - {15'b0, cal.t1, 1'b0};
			d_s1  <= {16'b0, raw_temperature[19:4]} - {16'b0, cal.t1};
			pt_s1 <= stpc_pkg::PressFull - {1'b0, raw_pressure};
			// s2
			x1m_s2 <= a_s1 * t2x;
			dd_s2  <= d_s1 * d_s1;
			pt_s2  <= pt_s1;
			// s3
			x1_s3  <= x1_c;
			x2m_s3 <= dd_sh * t3x;
			pt_s3  <= pt_s2;
			// s4: fine temperature
			fine_s4 <= x1_s3 + x2_c;
			pt_s4   <= pt_s3;
			// s5: centi degrees, pressure offset term
			sd_s5.temp  <= temp_c;
			sd_s5.fine  <= fine_s4;
			sd_s5.neg   <= 1'b0;
			sd_s5.dzero <= 1'b0;
			v1_s5       <= v1_c;
			pt_s5       <= pt_s4;
			// s6: square and linear products
			sq_s6 <= sq_full[63:0];
			m5_s6 <= {{15{m5_full[48]}}, m5_full};
			m2_s6 <= {{15{m2_full[48]}}, m2_full};
			sd_s6 <= sd_s5;
			pt_s6 <= pt_s5;
			// s7: quadratic coefficients
			a_s7  <= a_c;
			d_s7  <= d_c;
			m5_s7 <= m5_s6;
			m2_s7 <= m2_s6;
			sd_s7 <= sd_s6;
			pt_s7 <= pt_s6;
			// s8: sums
			v2_s8 <= v2_c;
			w_s8  <= w_c;
			sd_s8 <= sd_s7;
			pt_s8 <= pt_s7;
			// s9: scale by P1
			w2m_s9 <= (stpc_pkg::CalOffset + w_s8) * {48'b0, cal.p1};
			v2_s9  <= v2_s8;
			sd_s9  <= sd_s8;
			pt_s9  <= pt_s8;
			// s10: divisor and raw dividend
			den_s10  <= den_c;
			num0_s10 <= num0_c;
			sd_s10   <= sd_s9;
			// s11
			num_s11 <= num0_s10 * stpc_pkg::PressScale;
			den_s11 <= den_s10;
			sd_s11  <= sd_s10;
			// s12: magnitudes and sign for the divider
			dout.rem        <= '0;
			dout.quo        <= '0;
			dout.num        <= an_c;
			dout.den        <= ad_c;
			dout.side.temp  <= sd_s11.temp;
			dout.side.fine  <= sd_s11.fine;
			dout.side.neg   <= num_s11[63] ^ den_s11[63];
			dout.side.dzero <= (den_s11 == 64'd0);
		end
	end

endmodule

// ===== rtl/stpc_back.sv =====
// ----------------------------------------------------------------------------
// stpc_back
// Quotient sign fix, second-order pressure terms and the output register.
// ----------------------------------------------------------------------------
module stpc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vin,
	input  stpc_pkg::div_t                din,
	input  stpc_pkg::calib_t              cal,
	output logic                          vout,
	output logic [stpc_pkg::OutW-1:0]     temp,
	output logic [stpc_pkg::OutW-1:0]     fine,
	output logic [stpc_pkg::OutW-1:0]     press,
	output logic                          dz
);

	logic [stpc_pkg::BackStages-1:0] vld_q;

	logic [63:0] p_sa, p_sb, p_sc, p_sd;
	logic [63:0] pp0_sb, m8_sb, qq_sc, v2b_sc, v2b_sd, m9_sd;
	logic [31:0] pp1_sb;
	stpc_pkg::side_t sd_sa, sd_sb, sd_sc, sd_sd;

	logic [63:0] q_c, v2b_c, v1b_c, sum_c, psh_c, press_c, p7x;
	logic [31:0] pp1x2;
	logic signed [63:0] m8_c, m9_c;

	always_comb begin
		q_c     = $signed(p_sa) >>> 13;
		m8_c    = $signed(p_sa) * $signed(cal.p8);
		pp1x2   = pp1_sb << 1;
		v2b_c   = $signed(m8_sb) >>> 19;
		m9_c    = $signed(qq_sc) * $signed(cal.p9);
		v1b_c   = $signed(m9_sd) >>> 25;
		sum_c   = p_sd + v1b_c + v2b_sd;
		psh_c   = $signed(sum_c) >>> 8;
		p7x     = {{44{cal.p7[15]}}, cal.p7, 4'b0};
		press_c = psh_c + p7x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[stpc_pkg::BackStages-2:0], vin};
		end
	end

	assign vout = vld_q[stpc_pkg::BackStages-1];

	always_ff @(posedge clk) begin
		if (en) begin
			// sa: signed quotient
			p_sa  <= din.side.neg ? (64'd0 - din.quo) : din.quo;
			sd_sa <= din.side;
			// sb: partial products of q*q, P8 term
			pp0_sb <= q_c[31:0] * q_c[31:0];
			pp1_sb <= q_c[31:0] * q_c[63:32];
			m8_sb  <= m8_c;
			p_sb   <= p_sa;
			sd_sb  <= sd_sa;
			// sc: q*q low 64 bits
			qq_sc  <= pp0_sb + {pp1x2, 32'b0};
			v2b_sc <= v2b_c;
			p_sc   <= p_sb;
			sd_sc  <= sd_sb;
			// sd: P9 term
			m9_sd  <= m9_c;
			v2b_sd <= v2b_sc;
			p_sd   <= p_sc;
			sd_sd  <= sd_sc;
			// output register
			temp  <= sd_sd.temp;
			fine  <= sd_sd.fine;
			press <= sd_sd.dzero ? '0 : press_c[31:0];
			dz    <= sd_sd.dzero;
		end
	end

endmodule

// ===== rtl/sensor_temp_pressure_compensation_core.sv =====
// ----------------------------------------------------------------------------
// sensor_temp_pressure_compensation_core: pipelined barometric compensation
// Pipeline: 12 front stages, 64 divider cells, 4 back stages and an output register.
// Throughput: one beat per cycle; the whole pipe stalls only on out_ready.
// Reset clears valids and calibration registers to zero.
// ----------------------------------------------------------------------------
`include "sensor_temp_pressure_compensation_core_macros.svh"

module sensor_temp_pressure_compensation_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [stpc_pkg::RawW-1:0]           raw_temperature,
	input  logic [stpc_pkg::RawW-1:0]           raw_pressure,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [stpc_pkg::OutW-1:0]    temperature_centi,
	output logic signed [stpc_pkg::OutW-1:0]    fine_temperature,
	output logic [stpc_pkg::OutW-1:0]           pressure_q24_8,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stpc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [stpc_pkg::CalW-1:0]           cfg_data
);

	logic [stpc_pkg::CalW-1:0] temp_calib_q, press_a_q, press_b_q, press_c_q;
	stpc_pkg::calib_t cal;
	logic adv;
	logic [stpc_pkg::DivCells:0] cell_v;
	stpc_pkg::div_t cell_d [stpc_pkg::DivCells:0];
	logic [stpc_pkg::OutW-1:0] temp_o, fine_o, press_o;
	logic res_dz;
	logic [31:0] chk_sum, chk_temp;

	// calibration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stpc_pkg::REG_TEMP_CALIB:    temp_calib_q <= cfg_data;
				stpc_pkg::REG_PRESS_CALIB_A: press_a_q    <= cfg_data;
				stpc_pkg::REG_PRESS_CALIB_B: press_b_q    <= cfg_data;
				stpc_pkg::REG_PRESS_CALIB_C: press_c_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack calibration words
	always_comb begin
		cal.t1 = temp_calib_q[15:0];
		cal.t2 = temp_calib_q[31:16];
		cal.t3 = temp_calib_q[47:32];
		cal.p1 = press_a_q[15:0];
		cal.p2 = press_a_q[31:16];
		cal.p3 = press_a_q[47:32];
		cal.p4 = press_b_q[15:0];
		cal.p5 = press_b_q[31:16];
		cal.p6 = press_b_q[47:32];
		cal.p7 = press_c_q[15:0];
		cal.p8 = press_c_q[31:16];
		cal.p9 = press_c_q[47:32];
	end

	// pipe advances whenever the output register is free or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	stpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv),
		.vin             (in_valid),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.cal             (cal),
		.vout            (cell_v[0]),
		.dout            (cell_d[0])
	);

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < stpc_pkg::DivCells; i++) begin : g_div
		stpc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vin    (cell_v[i]),
			.din    (cell_d[i]),
			.vout   (cell_v[i+1]),
			.dout   (cell_d[i+1])
		);
	end

	stpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (cell_v[stpc_pkg::DivCells]),
		.din    (cell_d[stpc_pkg::DivCells]),
		.cal    (cal),
		.vout   (out_valid),
		.temp   (temp_o),
		.fine   (fine_o),
		.press  (press_o),
		.dz     (res_dz)
	);

	assign temperature_centi = temp_o;
	assign fine_temperature  = fine_o;
	assign pressure_q24_8    = press_o;

	// temperature recomputed from the delivered fine term
	assign chk_sum  = fine_o + (fine_o << 2) + stpc_pkg::TempRound;
	assign chk_temp = $signed(chk_sum) >>> 8;

	`STPC_ASSERT_NEXT(a_stall_freezes_chain, clk, arst_n, !in_ready, $stable(cell_v))
	`STPC_ASSERT_NOW(a_temp_matches_fine, clk, arst_n, out_valid, temp_o == chk_temp)
	`STPC_ASSERT_NOW(a_zero_div_press, clk, arst_n, out_valid && res_dz, pressure_q24_8 == '0)

endmodule
